[rtl/adts_fs_pkg.sv]
// Shared types and codes for the ADTS frame synchronizer.
// Used by adts_frame_sync and its port checker; no dependencies.
package adts_fs_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE_LOW  = 2'd0;
  localparam logic [1:0] REG_RATE_HIGH = 2'd1;
  localparam logic [1:0] REG_CH_REQ    = 2'd2;
  localparam logic [1:0] REG_CH_EN     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_MID       = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_RATE_BAD  = 3'd2;
  localparam logic [2:0] ST_CH_BAD    = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_SYNC_LOST = 3'd5;

  localparam logic [7:0]  SYNC_BYTE = 8'hff;
  localparam logic [3:0]  SYNC_NIB  = 4'hf;
  localparam logic [12:0] MIN_FRAME = 13'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [2:0] status;
    logic       chunk_last;
    logic       run_last;
  } res_t;

endpackage

[rtl/adts_frame_sync.sv]
// ADTS frame synchronizer top level: sync hunt, header checks, result queue.
// Depends on adts_fs_pkg.
//
// Usage: payload bytes enter on the s_axis channel (tdata = byte, tlast = last
// byte of a transport chunk). Delimited frame bytes leave on m_axis with
// tdata = byte, tlast = last byte of a frame or of an aborted frame, and
// tuser = frame_first, status, chunk_last_out, run_last. A byte yields zero,
// one or two result words; two only for the second sync byte, which also
// releases the held 0xFF.
// A result word is registered into the result queue when its byte is accepted.
// Throughput: one input byte per cycle while each byte gives at most one
// word and m_axis_tready stays high; the output side moves one word per cycle.
// The three-entry result queue holds the extra word of a two-word byte.
// Stall: when m_axis_tready is low, words wait in the queue and s_axis_tready
// drops once the queue cannot take two more words.
// Reset: the queue empties, hunting restarts and the configuration returns
// to rate window 3..5, required channel configuration 0, channel check on.
// Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i.
module adts_frame_sync (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // chunk_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // frame_last
  output logic [5:0] m_axis_tuser    // [0] frame_first, [3:1] status,
                                     // [4] chunk_last_out, [5] run_last
);
  import adts_fs_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_HUNT_FF = 3'd1;
  localparam logic [2:0] PH_FRAME   = 3'd2;
  localparam logic [2:0] PH_EXPECT  = 3'd3;
  localparam logic [2:0] PH_SYNC_FF = 3'd4;

  logic [3:0] rate_lo_q, rate_hi_q;
  logic [2:0] ch_req_q;
  logic       ch_en_q;

  logic [2:0]  phase_q, phase_d;
  logic [12:0] idx_q, idx_d;
  logic [12:0] len_q, len_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [1:0]  flags_q, flags_d;

  logic [1:0] cnt_q, cnt_d;
  res_t       q_q [3];
  res_t       q_d [3];

  logic       pop, acc;
  logic [1:0] base;
  logic [1:0] nres;
  res_t       r0, r1;

  logic [7:0]  b;
  logic        nib;
  logic [3:0]  sf;
  logic [2:0]  ch;
  logic [12:0] len_new;
  logic [13:0] idx_inc;
  logic        last;
  logic [2:0]  st;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_lo_q <= 4'd3;
      rate_hi_q <= 4'd5;
      ch_req_q  <= 3'd0;
      ch_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RATE_LOW:  rate_lo_q <= cfg_wdata_i;
        REG_RATE_HIGH: rate_hi_q <= cfg_wdata_i;
        REG_CH_REQ:    ch_req_q  <= cfg_wdata_i[2:0];
        REG_CH_EN:     ch_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign base          = cnt_q - {1'b0, pop};
  assign s_axis_tready = (base <= 2'd1);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign b       = s_axis_tdata;
  assign nib     = (b[7:4] == SYNC_NIB);
  assign sf      = b[5:2];
  assign ch      = {hdr_q[0], b[7:6]};
  assign len_new = len_q | {10'd0, b[7:5]};
  assign idx_inc = {1'b0, idx_q} + 14'd1;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    hdr_d   = hdr_q;
    flags_d = flags_q;
    nres    = 2'd0;
    last    = 1'b0;
    st      = ST_MID;
    r0      = '{data: b, first: 1'b0, last: 1'b0, status: ST_MID,
                chunk_last: 1'b0, run_last: 1'b0};
    r1      = r0;

    case (phase_q)
      PH_HUNT_FF, PH_SYNC_FF: begin
        if (nib) begin
          // Release the held 0xFF ahead of this byte
          r0.data  = SYNC_BYTE;
          r0.first = 1'b1;
          nres     = 2'd2;
          phase_d  = PH_FRAME;
          idx_d    = 13'd2;
          len_d    = '0;
          hdr_d    = '0;
          flags_d  = '0;
        end else if (phase_q == PH_SYNC_FF) begin
          r0.status = ST_SYNC_LOST;
          nres      = 2'd1;
          phase_d   = PH_HUNT;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_FRAME: begin
        case (idx_q)
          13'd2: begin
            hdr_d = b;
            if (sf < rate_lo_q || sf > rate_hi_q) flags_d[0] = 1'b1;
          end
          13'd3: begin
            if (ch_en_q && ch != ch_req_q) flags_d[1] = 1'b1;
            len_d = {b[1:0], 11'd0};
          end
          13'd4: len_d = len_q | {2'd0, b, 3'd0};
          13'd5: len_d = len_new;
          default: ;
        endcase
        if (idx_q == 13'd5 && len_new < MIN_FRAME) begin
          last    = 1'b1;
          st      = ST_BAD_LEN;
          phase_d = PH_HUNT;
        end else if (idx_q >= 13'd6 && idx_inc == {1'b0, len_q}) begin
          last    = 1'b1;
          st      = flags_q[0] ? ST_RATE_BAD : (flags_q[1] ? ST_CH_BAD : ST_OK);
          phase_d = PH_EXPECT;
        end
        r0.last   = last;
        r0.status = st;
        nres      = 2'd1;
        idx_d     = idx_inc[12:0];
      end
      PH_EXPECT: begin
        if (b == SYNC_BYTE) begin
          phase_d = PH_SYNC_FF;
        end else begin
          r0.status = ST_SYNC_LOST;
          nres      = 2'd1;
          phase_d   = PH_HUNT;
        end
      end
      default: phase_d = (b == SYNC_BYTE) ? PH_HUNT_FF : PH_HUNT;
    endcase

    // Mark the final word of this byte
    if (nres == 2'd2) begin
      r1.run_last   = 1'b1;
      r1.chunk_last = s_axis_tlast;
    end else begin
      r0.run_last   = 1'b1;
      r0.chunk_last = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
      len_q   <= '0;
      hdr_q   <= '0;
      flags_q <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      hdr_q   <= hdr_d;
      flags_q <= flags_d;
    end
  end

  // Result queue: advance on pop, append new words behind what stays
  always_comb begin
    q_d = q_q;
    if (pop) begin
      q_d[0] = q_q[1];
      q_d[1] = q_q[2];
    end
    if (acc && nres != 2'd0) q_d[base] = r0;
    if (acc && nres == 2'd2) q_d[base + 2'd1] = r1;
    cnt_d = base + (acc ? nres : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = q_q[0].data;
  assign m_axis_tlast  = q_q[0].last;
  assign m_axis_tuser  = {q_q[0].run_last, q_q[0].chunk_last, q_q[0].status, q_q[0].first};

endmodule

[rtl/adts_fs_checker.sv]
// Port-level checker for adts_frame_sync, attached by bind.
// Depends on adts_fs_pkg.
module adts_fs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [5:0] m_axis_tuser
);
  import adts_fs_pkg::*;

  logic [2:0] status;
  logic       first, clast, rlast;

  assign first  = m_axis_tuser[0];
  assign status = m_axis_tuser[3:1];
  assign clast  = m_axis_tuser[4];
  assign rlast  = m_axis_tuser[5];

  // Hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled word changed");

  // The first sync byte is always followed by a word of the same input
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && first |-> !rlast && !m_axis_tlast && status == ST_MID
      && m_axis_tdata == SYNC_BYTE)
    else $error("bad frame start word");

  // A frame end always carries an end status
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> status != ST_MID && status != ST_SYNC_LOST)
    else $error("frame end without end status");

  // Sync loss stands alone and ends its input's run
  a_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_SYNC_LOST |-> !first && !m_axis_tlast && rlast)
    else $error("bad sync lost word");

  a_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && clast |-> rlast)
    else $error("chunk end on a non-final word");

endmodule

bind adts_frame_sync adts_fs_checker u_adts_fs_checker (.*);
